// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ESDP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked on every rising clock edge, reset included.
`define ESDP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// File: rtl/core/esdp_pkg.sv
// ----------------------------------------------------------------------------
// esdp_pkg
// Types and constants of the ES descriptor parser.
// ----------------------------------------------------------------------------
package esdp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       atom_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  error_code;
        logic [7:0]  version;
        logic [23:0] flags;
        logic [7:0]  object_type;
        logic [7:0]  stream_type;
        logic [23:0] buffer_size;
        logic [31:0] max_bitrate;
        logic [31:0] avg_bitrate;
        logic [27:0] config_len;
        logic [7:0]  config_byte;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_res_push;

    localparam logic [1:0] KIND_HDR  = 2'd0;
    localparam logic [1:0] KIND_BYTE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [2:0] ERR_TRUNCATED    = 3'd1;
    localparam logic [2:0] ERR_ES_SHORT     = 3'd2;
    localparam logic [2:0] ERR_CFG_TAG      = 3'd3;
    localparam logic [2:0] ERR_CFG_SHORT    = 3'd4;
    localparam logic [2:0] ERR_SPECIFIC_TAG = 3'd5;

    localparam logic [7:0] TAG_ES       = 8'h03;
    localparam logic [7:0] TAG_DEC_CFG  = 8'h04;
    localparam logic [7:0] TAG_SPECIFIC = 8'h05;

    localparam logic [27:0] ES_MIN_SIZE       = 28'd20;
    localparam logic [27:0] CFG_MIN_SIZE      = 28'd13;
    localparam logic [27:0] CFG_SPECIFIC_SIZE = 28'd15;

    localparam logic [2:0] MAX_LENGTH_BYTES = 3'd4;

endpackage

// File: rtl/core/es_descriptor_parser_unit.sv
// ----------------------------------------------------------------------------
// es_descriptor_parser_unit
// Parses the payload of an MP4 esds atom, one byte per transfer.
// ----------------------------------------------------------------------------
// Each result is registered in the output buffer, in its main register or skid entry.
// Throughput: one input byte per cycle while the input is not stalled.
// The input stalls only while the two-entry result buffer is full.
// Reset is synchronous and active low; it returns the parser to the version
// byte and empties the result buffer.
module es_descriptor_parser_unit
    import esdp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic      take;
    logic      full;
    t_res_push res;

    assign take       = i_in_valid && !full;
    assign o_in_stall = full;

    esdp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (i_in_item),
        .o_res   (res)
    );

    esdp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_full  (full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

endmodule

// File: rtl/core/esdp_parser.sv
// ----------------------------------------------------------------------------
// esdp_parser
// Byte-wise parse state and result formation for one esds payload byte.
// ----------------------------------------------------------------------------
module esdp_parser
    import esdp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_take,
    input  t_in_item  i_item,
    output t_res_push o_res
);

    typedef enum logic [4:0] {
        PH_VER, PH_FLAGS, PH_TAG1, PH_LEN1, PH_SKIP, PH_TAG2, PH_LEN2,
        PH_OBJ, PH_STREAM, PH_BUF, PH_MAXBR, PH_AVGBR, PH_TAG3, PH_LEN3,
        PH_DATA, PH_DONE, PH_ERR
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_cnt, n_cnt;
    logic [27:0] r_acc, n_acc;
    logic [2:0]  r_lcnt, n_lcnt;
    logic [7:0]  r_ver, n_ver;
    logic [23:0] r_flags, n_flags;
    logic [7:0]  r_obj, n_obj;
    logic [7:0]  r_stream, n_stream;
    logic [23:0] r_buf, n_buf;
    logic [31:0] r_maxbr, n_maxbr;
    logic [31:0] r_avgbr, n_avgbr;
    logic [27:0] r_rem, n_rem;
    logic        r_first_es, n_first_es;

    logic [7:0]  b;
    logic [27:0] acc_shift;
    logic [2:0]  lcnt_inc;
    logic        len_done;
    logic [2:0]  cnt_inc;
    logic [2:0]  cnt_dec;
    logic [27:0] rem_dec;
    logic        err;
    t_out_item   hdr;
    t_out_item   err_item;
    t_res_push   res;

    assign b         = i_item.data_byte;
    assign acc_shift = {r_acc[20:0], b[6:0]};
    assign lcnt_inc  = r_lcnt + 3'd1;
    assign len_done  = !b[7] || (lcnt_inc >= MAX_LENGTH_BYTES);
    assign cnt_inc   = r_cnt + 3'd1;
    assign cnt_dec   = r_cnt - 3'd1;
    assign rem_dec   = r_rem - 28'd1;

    always_comb begin
        hdr             = '0;
        hdr.kind        = KIND_HDR;
        hdr.version     = r_ver;
        hdr.flags       = r_flags;
        hdr.object_type = r_obj;
        hdr.stream_type = r_stream;
        hdr.buffer_size = r_buf;
        hdr.max_bitrate = r_maxbr;
        hdr.avg_bitrate = r_avgbr;
        err_item        = '0;
        err_item.kind   = KIND_ERR;
        err_item.last   = 1'b1;

        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_acc      = r_acc;
        n_lcnt     = r_lcnt;
        n_ver      = r_ver;
        n_flags    = r_flags;
        n_obj      = r_obj;
        n_stream   = r_stream;
        n_buf      = r_buf;
        n_maxbr    = r_maxbr;
        n_avgbr    = r_avgbr;
        n_rem      = r_rem;
        n_first_es = r_first_es;
        res        = '0;
        err        = 1'b0;

        unique case (r_phase)
            PH_VER: begin
                n_ver   = b;
                n_cnt   = 3'd0;
                n_phase = PH_FLAGS;
            end
            PH_FLAGS: begin
                n_flags = {r_flags[15:0], b};
                n_cnt   = cnt_inc;
                if (cnt_inc >= 3'd3) begin
                    n_phase = PH_TAG1;
                end
            end
            PH_TAG1: begin
                n_first_es = (b == TAG_ES);
                n_acc      = '0;
                n_lcnt     = '0;
                n_phase    = PH_LEN1;
            end
            PH_LEN1: begin
                n_acc  = acc_shift;
                n_lcnt = lcnt_inc;
                if (len_done) begin
                    if (r_first_es && (acc_shift < ES_MIN_SIZE)) begin
                        res.valid           = 1'b1;
                        res.item            = err_item;
                        res.item.error_code = ERR_ES_SHORT;
                        err                 = 1'b1;
                        n_phase             = PH_ERR;
                    end else begin
                        n_cnt   = r_first_es ? 3'd3 : 3'd2;
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                n_cnt = cnt_dec;
                if (cnt_dec == 3'd0) begin
                    n_phase = PH_TAG2;
                end
            end
            PH_TAG2: begin
                if (b != TAG_DEC_CFG) begin
                    res.valid           = 1'b1;
                    res.item            = err_item;
                    res.item.error_code = ERR_CFG_TAG;
                    err                 = 1'b1;
                    n_phase             = PH_ERR;
                end else begin
                    n_acc   = '0;
                    n_lcnt  = '0;
                    n_phase = PH_LEN2;
                end
            end
            PH_LEN2: begin
                n_acc  = acc_shift;
                n_lcnt = lcnt_inc;
                if (len_done) begin
                    if (acc_shift < CFG_MIN_SIZE) begin
                        res.valid           = 1'b1;
                        res.item            = err_item;
                        res.item.error_code = ERR_CFG_SHORT;
                        err                 = 1'b1;
                        n_phase             = PH_ERR;
                    end else begin
                        n_phase = PH_OBJ;
                    end
                end
            end
            PH_OBJ: begin
                n_obj   = b;
                n_phase = PH_STREAM;
            end
            PH_STREAM: begin
                n_stream = b;
                n_cnt    = 3'd0;
                n_phase  = PH_BUF;
            end
            PH_BUF: begin
                n_buf = {r_buf[15:0], b};
                n_cnt = cnt_inc;
                if (cnt_inc >= 3'd3) begin
                    n_cnt   = 3'd0;
                    n_phase = PH_MAXBR;
                end
            end
            PH_MAXBR: begin
                n_maxbr = {r_maxbr[23:0], b};
                n_cnt   = cnt_inc;
                if (cnt_inc >= 3'd4) begin
                    n_cnt   = 3'd0;
                    n_phase = PH_AVGBR;
                end
            end
            PH_AVGBR: begin
                n_avgbr = {r_avgbr[23:0], b};
                n_cnt   = cnt_inc;
                if (cnt_inc >= 3'd4) begin
                    n_cnt = 3'd0;
                    if (r_acc >= CFG_SPECIFIC_SIZE) begin
                        n_phase = PH_TAG3;
                    end else begin
                        res.valid            = 1'b1;
                        res.item             = hdr;
                        res.item.avg_bitrate = {r_avgbr[23:0], b};
                        res.item.last        = 1'b1;
                        n_phase              = PH_DONE;
                    end
                end
            end
            PH_TAG3: begin
                if (b != TAG_SPECIFIC) begin
                    res.valid           = 1'b1;
                    res.item            = err_item;
                    res.item.error_code = ERR_SPECIFIC_TAG;
                    err                 = 1'b1;
                    n_phase             = PH_ERR;
                end else begin
                    n_acc   = '0;
                    n_lcnt  = '0;
                    n_phase = PH_LEN3;
                end
            end
            PH_LEN3: begin
                n_acc  = acc_shift;
                n_lcnt = lcnt_inc;
                if (len_done) begin
                    n_rem               = acc_shift;
                    res.valid           = 1'b1;
                    res.item            = hdr;
                    res.item.config_len = acc_shift;
                    res.item.last       = (acc_shift == 28'd0);
                    n_phase             = (acc_shift == 28'd0) ? PH_DONE : PH_DATA;
                end
            end
            PH_DATA: begin
                n_rem                = rem_dec;
                res.valid            = 1'b1;
                res.item             = '0;
                res.item.kind        = KIND_BYTE;
                res.item.config_byte = b;
                res.item.last        = (rem_dec == 28'd0);
                if (rem_dec == 28'd0) begin
                    n_phase = PH_DONE;
                end
            end
            default: begin
            end
        endcase

        if (i_item.atom_end) begin
            if (!err && (n_phase != PH_DONE) && (n_phase != PH_ERR)) begin
                res.valid           = 1'b1;
                res.item            = err_item;
                res.item.error_code = ERR_TRUNCATED;
            end
            n_phase    = PH_VER;
            n_cnt      = '0;
            n_acc      = '0;
            n_lcnt     = '0;
            n_rem      = '0;
            n_first_es = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_VER;
            r_cnt      <= '0;
            r_acc      <= '0;
            r_lcnt     <= '0;
            r_ver      <= '0;
            r_flags    <= '0;
            r_obj      <= '0;
            r_stream   <= '0;
            r_buf      <= '0;
            r_maxbr    <= '0;
            r_avgbr    <= '0;
            r_rem      <= '0;
            r_first_es <= 1'b0;
        end else if (i_take) begin
            r_phase    <= n_phase;
            r_cnt      <= n_cnt;
            r_acc      <= n_acc;
            r_lcnt     <= n_lcnt;
            r_ver      <= n_ver;
            r_flags    <= n_flags;
            r_obj      <= n_obj;
            r_stream   <= n_stream;
            r_buf      <= n_buf;
            r_maxbr    <= n_maxbr;
            r_avgbr    <= n_avgbr;
            r_rem      <= n_rem;
            r_first_es <= n_first_es;
        end
    end

    always_comb begin
        o_res       = res;
        o_res.valid = res.valid && i_take;
    end

endmodule

// File: rtl/core/esdp_out_buf.sv
// ----------------------------------------------------------------------------
// esdp_out_buf
// Result register with a skid entry between the parser and the output port.
// ----------------------------------------------------------------------------
module esdp_out_buf
    import esdp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_res_push i_res,
    output logic      o_full,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    logic      r_main_valid;
    t_out_item r_main;
    logic      r_skid_valid;
    t_out_item r_skid;
    logic      pop;

    assign pop = r_main_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (pop) begin
                if (r_skid_valid) begin
                    r_main       <= r_skid;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_main_valid <= i_res.valid;
                    r_main       <= i_res.item;
                end
            end else if (!r_main_valid) begin
                r_main_valid <= i_res.valid;
                r_main       <= i_res.item;
            end else if (i_res.valid) begin
                r_skid_valid <= 1'b1;
                r_skid       <= i_res.item;
            end
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_item  = r_main;

endmodule

// File: rtl/core/esdp_checker.sv
// ----------------------------------------------------------------------------
// esdp_checker
// Port-level checks of the ES descriptor parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module esdp_checker
    import esdp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    `ESDP_ASSERT_ALWAYS(a_reset_empty, i_clk,
        !i_rst_n |=> !o_out_valid && !o_in_stall)
    `ESDP_ASSERT(a_in_hold, i_clk, i_rst_n,
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_item))
    `ESDP_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall |=> $stable(o_out_item))
    `ESDP_ASSERT(a_err_last, i_clk, i_rst_n,
        o_out_valid && o_out_item.kind == KIND_ERR |->
            o_out_item.last && o_out_item.config_byte == 8'd0)
    `ESDP_ASSERT(a_byte_clean, i_clk, i_rst_n,
        o_out_valid && o_out_item.kind == KIND_BYTE |->
            o_out_item.error_code == 3'd0 && o_out_item.config_len == 28'd0)

endmodule

bind es_descriptor_parser_unit esdp_checker u_esdp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
